@@ rtl/core/ihp_pkg.sv @@
package ihp_pkg;

   localparam int REQ_W = 24;
   localparam int RSP_W = 248;

   localparam logic [1:0] IP_NONE = 2'd0;
   localparam logic [1:0] IP_V4   = 2'd1;
   localparam logic [1:0] IP_V6   = 2'd2;

   localparam logic [1:0] PC_OTHER = 2'd0;
   localparam logic [1:0] PC_TCP   = 2'd1;
   localparam logic [1:0] PC_UDP   = 2'd2;
   localparam logic [1:0] PC_ICMP  = 2'd3;

   localparam logic [7:0] NH_HOPOPT  = 8'd0;
   localparam logic [7:0] NH_ICMP    = 8'd1;
   localparam logic [7:0] NH_TCP     = 8'd6;
   localparam logic [7:0] NH_UDP     = 8'd17;
   localparam logic [7:0] NH_ROUTING = 8'd43;
   localparam logic [7:0] NH_FRAG    = 8'd44;
   localparam logic [7:0] NH_ICMP6   = 8'd58;
   localparam logic [7:0] NH_NONE    = 8'd59;
   localparam logic [7:0] NH_DSTOPT  = 8'd60;

   localparam logic [3:0] VER_4 = 4'd4;
   localparam logic [3:0] VER_6 = 4'd6;

   // result record; first member is the top bit, so ip_class lands lowest
   typedef struct packed {
      logic [17:0] frag_info;
      logic [31:0] payload_info;
      logic [15:0] icmp_type_code;
      logic [63:0] tcp_seq_ack;
      logic [7:0]  tcp_flag_bits;
      logic [15:0] dest_port;
      logic [15:0] source_port;
      logic [7:0]  hop_ttl;
      logic [31:0] dest_ip;
      logic [31:0] source_ip;
      logic [1:0]  proto_class;
      logic [1:0]  ip_class;
   } rec_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_VER,
      ST_V4_FRAG,
      ST_V4_TTL,
      ST_V4_PROTO,
      ST_V4_SRC,
      ST_V4_DST,
      ST_V6_HDR,
      ST_V6_SRC,
      ST_V6_DST,
      ST_WALK,
      ST_EXT,
      ST_FRAG,
      ST_TRANS,
      ST_TCP,
      ST_UDP,
      ST_ICMP,
      ST_EMIT
   } bstate_type;

endpackage

@@ rtl/core/ip_transport_header_parser.sv @@
// Input: one packet byte per cycle while a bank is free, no gaps needed; two
// packet banks let the next packet stream in while the previous one is parsed.
// Parse: each header byte is read in an address phase, then a data phase
// (registered RAM read); IPv6 option and fragment headers are walked one by one,
// and the result waits in an output register until taken. A packet that ends
// before the one ahead of it has been parsed and sent stalls the input.
// Reset: synchronous, clears control only; RAM needs no clearing pass.
module ip_transport_header_parser #(
   parameter int LEN_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ihp_pkg::REQ_W-1:0] req_tdata,  // data_byte[7:0], pkt_len[23:8]
   input  logic                      req_tlast,  // last_byte
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // ip_class, proto_class, source_ip, dest_ip, hop_ttl, source_port, dest_port,
   // tcp_flag_bits, tcp_seq_ack, icmp_type_code, payload_info, frag_info, pad
   output logic [ihp_pkg::RSP_W-1:0] rsp_tdata
);
   import ihp_pkg::*;

   logic                wr_en;
   logic [LEN_BITS:0]   wr_addr, rd_addr;
   logic [7:0]          wr_data, rd_data;
   logic                q_push, q_pop, q_valid;
   logic [2*LEN_BITS:0] q_wdata, q_rdata;
   rel_type             rel;
   rec_type             rec;

   ihp_front #(.LEN_BITS(LEN_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rel(rel),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .q_push(q_push), .q_data(q_wdata)
   );

   ihp_ram #(.WIDTH(8), .DEPTH(2 ** (LEN_BITS + 1))) u_ram (
      .clock(clock),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   ihp_queue #(.WIDTH(2 * LEN_BITS + 1)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_wdata),
      .pop(q_pop), .valid(q_valid), .data(q_rdata)
   );

   ihp_back #(.LEN_BITS(LEN_BITS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_data(q_rdata), .q_pop(q_pop),
      .rd_addr(rd_addr), .rd_data(rd_data),
      .rel(rel),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_rec(rec)
   );

   assign rsp_tdata = {2'b00, rec};

endmodule

@@ rtl/core/ihp_ram.sv @@
module ihp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ihp_queue.sv @@
module ihp_queue #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] data
);

   logic [WIDTH-1:0] ent_ff [2];
   logic             wp_ff, wp_in;
   logic             rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_data;
      end
   end

   assign valid = (cnt_ff != 2'd0);
   assign data  = ent_ff[rp_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2 || pop))
      else $error("descriptor queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != 2'd0))
      else $error("descriptor queue underflow");

endmodule

@@ rtl/core/ihp_front.sv @@
module ihp_front #(
   parameter int LEN_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ihp_pkg::REQ_W-1:0] req_tdata,
   input  logic                    req_tlast,
   input  ihp_pkg::rel_type        rel,
   output logic                    wr_en,
   output logic [LEN_BITS:0]       wr_addr,
   output logic [7:0]              wr_data,
   output logic                    q_push,
   output logic [2*LEN_BITS:0]     q_data
);
   import ihp_pkg::*;

   logic [LEN_BITS-1:0] idx_ff, idx_in;
   logic                bank_ff, bank_in;
   logic [1:0]          busy_ff, busy_in;
   logic                acc;

   assign req_tready = !busy_ff[bank_ff];
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      idx_in  = idx_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (acc) begin
         if (req_tlast) begin
            // hand the bank to the back end and switch
            idx_in           = '0;
            bank_in          = !bank_ff;
            busy_in[bank_ff] = 1'b1;
         end else if (idx_ff != '1) begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         idx_ff  <= idx_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

   assign wr_en   = acc;
   assign wr_addr = {bank_ff, idx_ff};
   assign wr_data = req_tdata[7:0];
   assign q_push  = acc && req_tlast;
   // bank, length, last written position
   assign q_data  = {bank_ff, req_tdata[8 +: LEN_BITS], idx_ff};

endmodule

@@ rtl/core/ihp_back.sv @@
module ihp_back #(
   parameter int LEN_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [2*LEN_BITS:0]   q_data,
   output logic                  q_pop,
   output logic [LEN_BITS:0]     rd_addr,
   input  logic [7:0]            rd_data,
   output ihp_pkg::rel_type      rel,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ihp_pkg::rec_type      rsp_rec
);
   import ihp_pkg::*;

   localparam int CW = (LEN_BITS > 12) ? LEN_BITS + 1 : 13;

   bstate_type          state_ff, state_in;
   logic                ph_ff, ph_in;
   logic [3:0]          k_ff, k_in;
   logic [LEN_BITS-1:0] pos_ff, pos_in;
   logic [2*LEN_BITS:0] desc_ff, desc_in;
   logic [LEN_BITS-1:0] cur_ff, cur_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic [7:0]          nh_ff, nh_in;
   logic [31:0]         acc_ff, acc_in;
   rec_type             rec_ff, rec_in;
   logic                ov_ff, ov_in;
   rec_type             orec_ff, orec_in;

   logic [LEN_BITS-1:0] d_cnt, d_len, q_len, base, fpos;
   logic                d_bank, is_fetch, last_k;
   logic [3:0]          nbytes;
   logic [7:0]          b;
   logic [5:0]          ihl, hl;
   logic [11:0]         el;
   logic [15:0]         w16, offb;

   assign d_cnt  = desc_ff[LEN_BITS-1:0];
   assign d_len  = desc_ff[2*LEN_BITS-1:LEN_BITS];
   assign d_bank = desc_ff[2*LEN_BITS];
   assign q_len  = q_data[2*LEN_BITS-1:LEN_BITS];

   always_comb begin
      is_fetch = 1'b1;
      base     = cur_ff;
      nbytes   = 4'd1;
      case (state_ff)
         ST_VER:      begin base = LEN_BITS'(0);  nbytes = 4'd1;  end
         ST_V4_FRAG:  begin base = LEN_BITS'(6);  nbytes = 4'd2;  end
         ST_V4_TTL:   begin base = LEN_BITS'(8);  nbytes = 4'd1;  end
         ST_V4_PROTO: begin base = LEN_BITS'(9);  nbytes = 4'd1;  end
         ST_V4_SRC:   begin base = LEN_BITS'(12); nbytes = 4'd4;  end
         ST_V4_DST:   begin base = LEN_BITS'(16); nbytes = 4'd4;  end
         ST_V6_HDR:   begin base = LEN_BITS'(6);  nbytes = 4'd2;  end
         ST_V6_SRC:   begin base = LEN_BITS'(20); nbytes = 4'd4;  end
         ST_V6_DST:   begin base = LEN_BITS'(36); nbytes = 4'd4;  end
         ST_EXT:      nbytes = 4'd2;
         ST_FRAG:     nbytes = 4'd4;
         ST_TCP:      nbytes = 4'd14;
         ST_UDP:      nbytes = 4'd4;
         ST_ICMP:     nbytes = 4'd2;
         default:     is_fetch = 1'b0;
      endcase
   end

   assign fpos    = base + LEN_BITS'(k_ff);
   assign rd_addr = {d_bank, fpos};
   assign last_k  = (k_ff == nbytes - 4'd1);
   // positions past the last byte written for this packet read zero
   assign b       = (pos_ff <= d_cnt) ? rd_data : 8'd0;
   assign ihl     = {b[3:0], 2'b00};
   assign hl      = {acc_ff[7:4], 2'b00};
   assign el      = {4'd0, b} + 12'd1 << 3;
   assign w16     = {acc_ff[7:0], b};
   assign offb    = {w16[12:0], 3'b000};

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      k_in     = k_ff;
      pos_in   = pos_ff;
      desc_in  = desc_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      nh_in    = nh_ff;
      acc_in   = acc_ff;
      rec_in   = rec_ff;
      ov_in    = ov_ff;
      orec_in  = orec_ff;
      q_pop    = 1'b0;
      rel      = '0;

      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end

      if (is_fetch) begin
         if (!ph_ff) begin
            ph_in  = 1'b1;
            pos_in = fpos;
         end else begin
            ph_in  = 1'b0;
            acc_in = {acc_ff[23:0], b};
            k_in   = last_k ? 4'd0 : k_ff + 4'd1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               desc_in  = q_data;
               rec_in   = '0;
               k_in     = 4'd0;
               ph_in    = 1'b0;
               state_in = (q_len == '0) ? ST_EMIT : ST_VER;
            end
         end
         ST_VER: begin
            if (ph_ff) begin
               state_in = ST_EMIT;
               if (b[7:4] == VER_4) begin
                  if (d_len >= LEN_BITS'(20) && ihl >= 6'd20 &&
                      LEN_BITS'(ihl) <= d_len) begin
                     rec_in.ip_class = IP_V4;
                     cur_in          = LEN_BITS'(ihl);
                     rem_in          = d_len - LEN_BITS'(ihl);
                     state_in        = ST_V4_FRAG;
                  end
               end else if (b[7:4] == VER_6) begin
                  if (d_len >= LEN_BITS'(40)) begin
                     rec_in.ip_class = IP_V6;
                     cur_in          = LEN_BITS'(40);
                     rem_in          = d_len - LEN_BITS'(40);
                     state_in        = ST_V6_HDR;
                  end
               end
            end
         end
         ST_V4_FRAG: begin
            if (ph_ff && last_k) begin
               rec_in.frag_info = {offb, offb != 16'd0, w16[13]};
               state_in         = ST_V4_TTL;
            end
         end
         ST_V4_TTL: begin
            if (ph_ff) begin
               rec_in.hop_ttl = b;
               state_in       = ST_V4_PROTO;
            end
         end
         ST_V4_PROTO: begin
            if (ph_ff) begin
               nh_in    = b;
               state_in = ST_V4_SRC;
            end
         end
         ST_V4_SRC: begin
            if (ph_ff && last_k) begin
               rec_in.source_ip = {acc_ff[23:0], b};
               state_in         = ST_V4_DST;
            end
         end
         ST_V4_DST: begin
            if (ph_ff && last_k) begin
               rec_in.dest_ip = {acc_ff[23:0], b};
               state_in       = ST_TRANS;
            end
         end
         ST_V6_HDR: begin
            if (ph_ff) begin
               if (last_k) begin
                  rec_in.hop_ttl = b;
                  state_in       = ST_V6_SRC;
               end else begin
                  nh_in = b;
               end
            end
         end
         ST_V6_SRC: begin
            if (ph_ff && last_k) begin
               rec_in.source_ip = {acc_ff[23:0], b};
               state_in         = ST_V6_DST;
            end
         end
         ST_V6_DST: begin
            if (ph_ff && last_k) begin
               rec_in.dest_ip = {acc_ff[23:0], b};
               state_in       = ST_WALK;
            end
         end
         ST_WALK: begin
            state_in = ST_TRANS;
            if (rem_ff != '0) begin
               case (nh_ff) inside
                  NH_HOPOPT, NH_ROUTING, NH_DSTOPT: begin
                     if (rem_ff >= LEN_BITS'(2)) state_in = ST_EXT;
                  end
                  NH_FRAG: begin
                     if (rem_ff >= LEN_BITS'(8)) state_in = ST_FRAG;
                  end
                  default: state_in = ST_TRANS;
               endcase
            end
         end
         ST_EXT: begin
            if (ph_ff && last_k) begin
               // next header is taken before the length check
               nh_in = acc_ff[7:0];
               if (CW'(el) > CW'(rem_ff)) begin
                  state_in = ST_TRANS;
               end else begin
                  cur_in   = cur_ff + LEN_BITS'(el);
                  rem_in   = rem_ff - LEN_BITS'(el);
                  state_in = ST_WALK;
               end
            end
         end
         ST_FRAG: begin
            if (ph_ff && last_k) begin
               nh_in            = acc_ff[23:16];
               rec_in.frag_info = {16'd0, w16[15:3] != 13'd0, b[0]};
               cur_in           = cur_ff + LEN_BITS'(8);
               rem_in           = rem_ff - LEN_BITS'(8);
               state_in         = ST_WALK;
            end
         end
         ST_TRANS: begin
            state_in = ST_EMIT;
            case (nh_ff) inside
               NH_TCP: begin
                  rec_in.proto_class = PC_TCP;
                  if (rem_ff >= LEN_BITS'(20)) state_in = ST_TCP;
               end
               NH_UDP: begin
                  rec_in.proto_class = PC_UDP;
                  if (rem_ff >= LEN_BITS'(8)) state_in = ST_UDP;
               end
               NH_ICMP, NH_ICMP6: begin
                  rec_in.proto_class = PC_ICMP;
                  if (rem_ff >= LEN_BITS'(8)) state_in = ST_ICMP;
               end
               default: rec_in.proto_class = PC_OTHER;
            endcase
         end
         ST_TCP: begin
            if (ph_ff) begin
               case (k_ff) inside
                  [4'd0:4'd1]: rec_in.source_port = {rec_ff.source_port[7:0], b};
                  [4'd2:4'd3]: rec_in.dest_port = {rec_ff.dest_port[7:0], b};
                  [4'd4:4'd11]: rec_in.tcp_seq_ack = {rec_ff.tcp_seq_ack[55:0], b};
                  4'd13: begin
                     rec_in.tcp_flag_bits = b;
                     if (hl >= 6'd20 && LEN_BITS'(hl) <= rem_ff) begin
                        rec_in.payload_info = {16'(cur_ff + LEN_BITS'(hl)),
                                               16'(rem_ff - LEN_BITS'(hl))};
                     end
                     state_in = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_UDP: begin
            if (ph_ff) begin
               if (k_ff < 4'd2) begin
                  rec_in.source_port = {rec_ff.source_port[7:0], b};
               end else begin
                  rec_in.dest_port = {rec_ff.dest_port[7:0], b};
               end
               if (last_k) begin
                  rec_in.payload_info = {16'(cur_ff + LEN_BITS'(8)),
                                         16'(rem_ff - LEN_BITS'(8))};
                  state_in = ST_EMIT;
               end
            end
         end
         ST_ICMP: begin
            if (ph_ff) begin
               rec_in.icmp_type_code = {rec_ff.icmp_type_code[7:0], b};
               if (last_k) state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in    = 1'b1;
               orec_in  = rec_ff;
               rel.valid = 1'b1;
               rel.bank  = d_bank;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff    <= 1'b0;
         k_ff     <= 4'd0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         k_ff     <= k_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      desc_ff <= desc_in;
      cur_ff  <= cur_in;
      rem_ff  <= rem_in;
      nh_ff   <= nh_in;
      acc_ff  <= acc_in;
      rec_ff  <= rec_in;
      orec_ff <= orec_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_rec    = orec_ff;

   a_phase_in_fetch: assert property (@(posedge clock) disable iff (reset)
      ph_ff |-> is_fetch)
      else $error("read phase outside a fetch state");
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("descriptor taken while busy");
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      rel.valid |=> rsp_tvalid)
      else $error("released bank without a result");

endmodule
